FILE: sv/tbs_pkg.sv
// Shared types and constants for the token bucket packet shaper.
// No dependencies; used by token_bucket_packet_shaper.
`default_nettype none

package tbs_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CAPACITY_RESET = 16'd10;

	typedef enum logic [2:0] {
		ST_TOKEN_ADDED   = 3'd0,
		ST_TOKEN_DROPPED = 3'd1,
		ST_PKT_QUEUED    = 3'd2,
		ST_PKT_TOO_BIG   = 3'd3,
		ST_PKT_QUEUE_FULL = 3'd4
	} status_t;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_PACKET = 1'b1
	} cmd_t;

	// one queued packet
	typedef struct packed {
		logic [31:0] number;
		logic [15:0] need;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: sv/tbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-during-write to the same address returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/token_bucket_packet_shaper.sv
// Top level of the token bucket packet shaper: bucket state, FIFO control, result register.
// Depends on tbs_pkg and tbs_ram (FIFO storage of packet number and need).
//
//  channel  | handshake                 | word
//  ---------+---------------------------+---------------------------------------------
//  item     | item_valid / item_stall   | cmd, tokens_needed
//  result   | result_valid / result_stall | status, arrival_number, released,
//           |                           |   released_number, released_need,
//           |                           |   bucket_level, queue_length
//  config   | cfg_write                 | cfg_data (bucket capacity)
//
// One word per cycle unless item_stall is high; each result shows in the next cycle.
// The head packet sits in a register and the one behind it is read from the RAM
// every cycle, so releases can follow one another back to back.
// Reset empties the queue and bucket, sets capacity to 10; no clearing pass.
// item_stall is high only while a result is held and result_stall is high.
`default_nettype none

module token_bucket_packet_shaper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [15:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        cmd,
	input  wire logic [15:0] tokens_needed,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       status,
	output logic [31:0]      arrival_number,
	output logic             released,
	output logic [31:0]      released_number,
	output logic [15:0]      released_need,
	output logic [15:0]      bucket_level,
	output logic [6:0]       queue_length
);

	typedef logic [tbs_pkg::PTR_W-1:0] ptr_t;
	typedef logic [tbs_pkg::CNT_W-1:0] cnt_t;

	function automatic ptr_t next_slot(input ptr_t p);
		return (p == ptr_t'(tbs_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// architectural state
	logic [15:0]     capacity_q;
	logic [15:0]     level_q;
	logic [31:0]     arrivals_q;
	ptr_t            head_ptr_q;
	ptr_t            tail_ptr_q;
	cnt_t            count_q;
	tbs_pkg::entry_t head_q;
	logic            fwd_valid_q;
	tbs_pkg::entry_t fwd_data_q;

	// result register
	logic            out_valid_q;
	tbs_pkg::status_t out_status_q;
	logic [31:0]     out_arrival_q;
	logic            out_released_q;
	logic [31:0]     out_rel_number_q;
	logic [15:0]     out_rel_need_q;
	logic [15:0]     out_level_q;
	cnt_t            out_count_q;

	logic            accept;
	logic            is_pkt;
	logic [31:0]     arrival_next;
	logic            too_big;
	logic            full;
	logic            push;
	logic            rel;
	logic [15:0]     level_tick;
	logic [15:0]     level_base;
	logic [15:0]     level_next;
	tbs_pkg::entry_t new_entry;
	tbs_pkg::entry_t rel_entry;
	tbs_pkg::entry_t next_entry;
	tbs_pkg::entry_t ram_rdata;
	tbs_pkg::status_t status_c;
	ptr_t            head_ptr_next;
	ptr_t            rd_addr;
	logic            do_push;
	logic            do_rel;
	cnt_t            count_next;

	assign item_stall = out_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	assign is_pkt       = (tbs_pkg::cmd_t'(cmd) == tbs_pkg::CMD_PACKET);
	assign arrival_next = arrivals_q + 32'd1;
	assign too_big      = tokens_needed > capacity_q;
	assign full         = count_q >= cnt_t'(tbs_pkg::QUEUE_DEPTH);
	assign push         = is_pkt & ~too_big & ~full;
	assign level_tick   = (level_q < capacity_q) ? level_q + 16'd1 : level_q;

	assign new_entry.number = arrival_next;
	assign new_entry.need   = tokens_needed;

	// entry behind the head: RAM data, or the word written while it was being read
	assign next_entry = fwd_valid_q ? fwd_data_q : ram_rdata;

	always_comb begin
		if (is_pkt) begin
			level_base = level_q;
			rel_entry  = new_entry;
			// a packet goes out at once only when it is alone in the queue
			rel        = push & (count_q == '0) & (level_q >= tokens_needed);
		end else begin
			level_base = level_tick;
			rel_entry  = head_q;
			rel        = (count_q != '0) & (level_tick >= head_q.need);
		end
		level_next = rel ? level_base - rel_entry.need : level_base;
	end

	always_comb begin
		if (!is_pkt) begin
			status_c = (level_q < capacity_q) ? tbs_pkg::ST_TOKEN_ADDED
			                                  : tbs_pkg::ST_TOKEN_DROPPED;
		end else if (too_big) begin
			status_c = tbs_pkg::ST_PKT_TOO_BIG;
		end else if (full) begin
			status_c = tbs_pkg::ST_PKT_QUEUE_FULL;
		end else begin
			status_c = tbs_pkg::ST_PKT_QUEUED;
		end
	end

	assign do_push       = accept & push;
	assign do_rel        = accept & rel;
	assign head_ptr_next = do_rel ? next_slot(head_ptr_q) : head_ptr_q;
	assign rd_addr       = next_slot(head_ptr_next);
	assign count_next    = cnt_t'(count_q + cnt_t'(do_push) - cnt_t'(do_rel));

	tbs_ram #(
		.WIDTH (tbs_pkg::ENTRY_W),
		.DEPTH (tbs_pkg::QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (tail_ptr_q),
		.wdata (new_entry),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= tbs_pkg::CAPACITY_RESET;
			level_q     <= '0;
			arrivals_q  <= '0;
			head_ptr_q  <= '0;
			tail_ptr_q  <= '0;
			count_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				capacity_q <= cfg_data;
			end
			fwd_valid_q <= do_push & (tail_ptr_q == rd_addr);
			head_ptr_q  <= head_ptr_next;
			count_q     <= count_next;
			if (do_push) begin
				tail_ptr_q <= next_slot(tail_ptr_q);
			end
			if (accept) begin
				level_q <= level_next;
				if (is_pkt) begin
					arrivals_q <= arrival_next;
				end
			end
		end
	end

	// head register and forward word carry payload only
	always_ff @(posedge clk) begin
		fwd_data_q <= new_entry;
		if (do_push && count_q == '0) begin
			head_q <= new_entry;
		end else if (do_rel) begin
			head_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q     <= status_c;
			out_arrival_q    <= is_pkt ? arrival_next : 32'd0;
			out_released_q   <= rel;
			out_rel_number_q <= rel ? rel_entry.number : 32'd0;
			out_rel_need_q   <= rel ? rel_entry.need : 16'd0;
			out_level_q      <= level_next;
			out_count_q      <= cnt_t'(count_q + cnt_t'(push) - cnt_t'(rel));
		end
	end

	assign result_valid    = out_valid_q;
	assign status          = out_status_q;
	assign arrival_number  = out_arrival_q;
	assign released        = out_released_q;
	assign released_number = out_rel_number_q;
	assign released_need   = out_rel_need_q;
	assign bucket_level    = out_level_q;
	assign queue_length    = 7'(out_count_q);

endmodule

`default_nettype wire
